[src/hrap_grid_to_lat_lon_top_macros.svh]
// Assertion macros for the checker file of the HRAP grid converter (hrap_chk.sv).
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef HRAP_GRID_TO_LAT_LON_TOP_MACROS_SVH
`define HRAP_GRID_TO_LAT_LON_TOP_MACROS_SVH

// Clocked check, switched off while reset is held.
`define HRAP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hrap check failed");

// Clocked check that also runs during reset.
`define HRAP_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hrap reset check failed");

`endif

[src/hrap_pkg.sv]
// Package for the HRAP grid to latitude/longitude converter.
// Control struct, fixed-point constants and the arctangent table; no dependencies.
`default_nettype none
package hrap_pkg;

  typedef struct packed {
    logic valid;
    logic pole;
  } ctl_t;

  localparam int ZW = 36;  // radian angles, Q.32, signed

  localparam int POLE_COL = 401;
  localparam int POLE_ROW = 1601;
  localparam int FRAC_SHIFT = 15;

  localparam logic [26:0] G_Q15 = 27'd81800082;
  localparam logic signed [ZW-1:0] PI_HALF_Q32 = 36'sd6746518852;
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

  localparam int DW = 28;  // degree values, Q.16, signed
  localparam logic signed [DW-1:0] DEG15  = 28'sd983040;
  localparam logic signed [DW-1:0] DEG90  = 28'sd5898240;
  localparam logic signed [DW-1:0] DEG360 = 28'sd23592960;
  localparam logic signed [DW-1:0] DEG375 = 28'sd24576000;

  // atan(2^-i) in Q.32 radians
  function automatic logic [31:0] atan_q32(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd3373259426;
      1:  v = 32'd1991351318;
      2:  v = 32'd1052175346;
      3:  v = 32'd534100635;
      4:  v = 32'd268086748;
      5:  v = 32'd134174063;
      6:  v = 32'd67103403;
      7:  v = 32'd33553749;
      8:  v = 32'd16777131;
      9:  v = 32'd8388597;
      10: v = 32'd4194303;
      default: begin
        if (i > 31) v = 32'd0;
        else v = 32'd1 << (32 - i);
      end
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/hrap_if.sv]
// Channel interfaces of the HRAP grid converter: grid point in, lat/lon out.
// Valid/ready handshake; depends on nothing.
`default_nettype none
interface hrap_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] grid_col;
  logic [COORD_BITS-1:0] grid_row;
  modport source (output valid, output grid_col, output grid_row, input ready);
  modport sink   (input valid, input grid_col, input grid_row, output ready);
endinterface

interface hrap_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] latitude;
  logic        [24:0] west_longitude;
  modport source (output valid, output latitude, output west_longitude, input ready);
  modport sink   (input valid, input latitude, input west_longitude, output ready);
endinterface
`default_nettype wire

[src/hrap_sqrt_cell.sv]
// One digit cell of the pipelined square root; also carries the longitude lane.
// Uses hrap_pkg.
`default_nettype none
module hrap_sqrt_cell #(
  parameter int NP = 28,
  parameter int XW = 13,
  parameter int ZW = 36
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     en,
  input  hrap_pkg::ctl_t          ctl_i,
  input  wire  [NP+1:0]           rem_i,
  input  wire  [NP-1:0]           root_i,
  input  wire  [2*NP-1:0]         v_i,
  input  wire  signed [XW-1:0]    lx_i,
  input  wire  signed [XW-1:0]    ly_i,
  input  wire  signed [ZW-1:0]    lz_i,
  output hrap_pkg::ctl_t          ctl_o,
  output logic [NP+1:0]           rem_o,
  output logic [NP-1:0]           root_o,
  output logic [2*NP-1:0]         v_o,
  output logic signed [XW-1:0]    lx_o,
  output logic signed [XW-1:0]    ly_o,
  output logic signed [ZW-1:0]    lz_o
);

  hrap_pkg::ctl_t         ctl_r;
  logic [NP+1:0]          rem_r, rem_nxt;
  logic [NP-1:0]          root_r, root_nxt;
  logic [2*NP-1:0]        v_r, v_nxt;
  logic signed [XW-1:0]   lx_r, ly_r;
  logic signed [ZW-1:0]   lz_r;
  logic [NP+3:0]          rem2, trial, diff;
  logic                   ge;

  always_comb begin
    rem2     = {rem_i, v_i[2*NP-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    diff     = rem2 - trial;
    ge       = (rem2 >= trial);
    rem_nxt  = ge ? diff[NP+1:0] : rem2[NP+1:0];
    root_nxt = {root_i[NP-2:0], ge};
    v_nxt    = {v_i[2*NP-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      v_r    <= v_nxt;
      lx_r   <= lx_i;
      ly_r   <= ly_i;
      lz_r   <= lz_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign v_o    = v_r;
  assign lx_o   = lx_r;
  assign ly_o   = ly_r;
  assign lz_o   = lz_r;

endmodule
`default_nettype wire

[src/hrap_cordic_cell.sv]
// One CORDIC vectoring micro-rotation, two lanes side by side (latitude, longitude).
// Uses hrap_pkg for the arctangent table.
`default_nettype none
module hrap_cordic_cell #(
  parameter int CW  = 31,
  parameter int ZW  = 36,
  parameter int IDX = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  hrap_pkg::ctl_t        ctl_i,
  input  wire  signed [CW-1:0]  ax_i,
  input  wire  signed [CW-1:0]  ay_i,
  input  wire  signed [ZW-1:0]  az_i,
  input  wire  signed [CW-1:0]  bx_i,
  input  wire  signed [CW-1:0]  by_i,
  input  wire  signed [ZW-1:0]  bz_i,
  output hrap_pkg::ctl_t        ctl_o,
  output logic signed [CW-1:0]  ax_o,
  output logic signed [CW-1:0]  ay_o,
  output logic signed [ZW-1:0]  az_o,
  output logic signed [CW-1:0]  bx_o,
  output logic signed [CW-1:0]  by_o,
  output logic signed [ZW-1:0]  bz_o
);

  localparam logic signed [ZW-1:0] ANG =
    $signed({{(ZW-32){1'b0}}, hrap_pkg::atan_q32(IDX)});

  hrap_pkg::ctl_t       ctl_r;
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [ZW-1:0] az_r, bz_r;
  logic signed [CW-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic signed [ZW-1:0] az_nxt, bz_nxt;

  always_comb begin
    if (!ay_i[CW-1]) begin
      ax_nxt = ax_i + (ay_i >>> IDX);
      ay_nxt = ay_i - (ax_i >>> IDX);
      az_nxt = az_i + ANG;
    end else begin
      ax_nxt = ax_i - (ay_i >>> IDX);
      ay_nxt = ay_i + (ax_i >>> IDX);
      az_nxt = az_i - ANG;
    end
    if (!by_i[CW-1]) begin
      bx_nxt = bx_i + (by_i >>> IDX);
      by_nxt = by_i - (bx_i >>> IDX);
      bz_nxt = bz_i + ANG;
    end else begin
      bx_nxt = bx_i - (by_i >>> IDX);
      by_nxt = by_i + (bx_i >>> IDX);
      bz_nxt = bz_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      az_r <= az_nxt;
      bx_r <= bx_nxt;
      by_r <= by_nxt;
      bz_r <= bz_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign ax_o  = ax_r;
  assign ay_o  = ay_r;
  assign az_o  = az_r;
  assign bx_o  = bx_r;
  assign by_o  = by_r;
  assign bz_o  = bz_r;

endmodule
`default_nettype wire

[src/hrap_deg_conv.sv]
// Radians (Q.32) to degrees (Q.16), rounded half away from zero; two stages.
// Uses hrap_pkg.
`default_nettype none
module hrap_deg_conv #(
  parameter int ZW = 36
) (
  input  wire                                 clk,
  input  wire                                 en,
  input  wire  signed [ZW-1:0]                rad_i,
  output logic signed [hrap_pkg::DW-1:0]      deg_o
);

  localparam int AW = ZW - 16;

  logic                          neg_r;
  logic [AW+29:0]                pa_r;
  logic [45:0]                   pb_r;
  logic signed [hrap_pkg::DW-1:0] deg_r, deg_nxt;
  logic [ZW-1:0]                 mag;
  logic [AW+29:0]                t, tr;
  logic [25:0]                   d;

  assign mag = rad_i[ZW-1] ? ZW'(-rad_i) : ZW'(rad_i);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= rad_i[ZW-1];
      pa_r  <= mag[ZW-1:16] * hrap_pkg::DEG_PER_RAD_Q24;
      pb_r  <= mag[15:0] * hrap_pkg::DEG_PER_RAD_Q24;
      deg_r <= deg_nxt;
    end
  end

  always_comb begin
    t  = pa_r + (AW+30)'(pb_r >> 16);
    tr = t + ((AW+30)'(1) << 23);
    d  = tr[49:24];
    deg_nxt = neg_r ? -$signed({2'b00, d}) : $signed({2'b00, d});
  end

  assign deg_o = deg_r;

endmodule
`default_nettype wire

[src/hrap_grid_to_lat_lon_top.sv]
// HRAP grid point to latitude / west longitude, inverse polar stereographic projection.
// Uses hrap_pkg, hrap_if, hrap_sqrt_cell, hrap_cordic_cell and hrap_deg_conv.
//
// Usage:
//  - in_ch carries one grid point (grid_col, grid_row) per transaction; out_ch
//    carries one (latitude, west_longitude) transaction per input, in order.
//    Both are valid/ready; a transaction completes when valid and ready are high.
//  - Throughput: one transaction per clock cycle, sustained while out_ch.ready stays high.
//  - Pipeline: offset, square and sum registers, a digit-per-cell square root chain
//    of NP cells (NP is the number of square root digits, 29 for COORD_BITS = 12),
//    a rotation-per-cell CORDIC chain of CORDIC_STEPS cells, degree conversion and
//    the output register; both chains are fully pipelined.
//  - Datapath: offset from the pole, squares, then a square root chain (one result
//    bit per cell) and a CORDIC chain whose cells rotate two vectors at once:
//    (g, r) for latitude and the pre-rotated (x, y) for longitude.
//  - Outputs are Q.16 degrees; the pole point gives latitude 90, longitude 15.
//  - Reset (rst_n low, synchronous) empties the pipeline: all valid flags clear.
//    There is no table to clear, so in_ch.ready rises straight after reset.
//  - Stall: when out_ch.ready is low, a waiting result is parked in a skid
//    register; the whole pipe then holds until the skid drains. in_ch.ready is
//    registered and drops only while the skid is occupied.
`default_nettype none
module hrap_grid_to_lat_lon_top #(
  parameter int COORD_BITS   = 12,
  parameter int CORDIC_STEPS = 24
) (
  input  wire        clk,
  input  wire        rst_n,
  hrap_in_if.sink    in_ch,
  hrap_out_if.source out_ch
);

  localparam int XW  = ((COORD_BITS > 11) ? COORD_BITS : 11) + 2;
  localparam int RRW = 2 * XW - 1;
  localparam int NP  = (RRW + 2 * hrap_pkg::FRAC_SHIFT + 1) / 2;
  localparam int VW  = 2 * NP;
  localparam int CW  = XW + 18;
  localparam int ZW  = hrap_pkg::ZW;
  localparam int NS  = CORDIC_STEPS;
  localparam int DW  = hrap_pkg::DW;
  localparam int FS  = hrap_pkg::FRAC_SHIFT;

  logic en;

  // skid / output
  logic                  skid_valid_r;
  logic signed [23:0]    skid_lat_r;
  logic        [24:0]    skid_lon_r;
  logic                  ov_r;
  logic signed [23:0]    olat_r, olat_nxt;
  logic        [24:0]    olon_r, olon_nxt;

  assign en = !skid_valid_r;
  assign in_ch.ready = !skid_valid_r;

  // stage 0: offsets from the pole
  hrap_pkg::ctl_t       ctl0_r;
  logic signed [XW-1:0] x0_r, y0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r.valid <= in_ch.valid;
      ctl0_r.pole  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= $signed({{(XW-COORD_BITS){1'b0}}, in_ch.grid_col[COORD_BITS-1:0]})
              - XW'(hrap_pkg::POLE_COL);
      y0_r <= $signed({{(XW-COORD_BITS){1'b0}}, in_ch.grid_row[COORD_BITS-1:0]})
              - XW'(hrap_pkg::POLE_ROW);
    end
  end

  // stage 1: squares, pole flag, quadrant pre-rotation of the longitude vector
  hrap_pkg::ctl_t       ctl1_r, ctl1_nxt;
  logic [RRW-1:0]       sqx_r, sqy_r;
  logic signed [XW-1:0] lx1_r, ly1_r, lx1_nxt, ly1_nxt;
  logic signed [ZW-1:0] lz1_r, lz1_nxt;
  logic signed [2*XW-1:0] px, py;

  always_comb begin
    px = x0_r * x0_r;
    py = y0_r * y0_r;
    ctl1_nxt.valid = ctl0_r.valid;
    ctl1_nxt.pole  = (x0_r == '0) && (y0_r == '0);
    if (!x0_r[XW-1]) begin
      lx1_nxt = x0_r;
      ly1_nxt = y0_r;
      lz1_nxt = '0;
    end else if (!y0_r[XW-1]) begin
      lx1_nxt = y0_r;
      ly1_nxt = -x0_r;
      lz1_nxt = hrap_pkg::PI_HALF_Q32;
    end else begin
      lx1_nxt = -y0_r;
      ly1_nxt = x0_r;
      lz1_nxt = -hrap_pkg::PI_HALF_Q32;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= px[RRW-1:0];
      sqy_r <= py[RRW-1:0];
      lx1_r <= lx1_nxt;
      ly1_r <= ly1_nxt;
      lz1_r <= lz1_nxt;
    end
  end

  // stage 2: r squared
  hrap_pkg::ctl_t       ctl2_r;
  logic [RRW-1:0]       rr_r;
  logic signed [XW-1:0] lx2_r, ly2_r;
  logic signed [ZW-1:0] lz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_r  <= sqx_r + sqy_r;
      lx2_r <= lx1_r;
      ly2_r <= ly1_r;
      lz2_r <= lz1_r;
    end
  end

  // square root chain: r = isqrt(rr << 30), one bit per cell
  hrap_pkg::ctl_t       sq_ctl  [0:NP];
  logic [NP+1:0]        sq_rem  [0:NP];
  logic [NP-1:0]        sq_root [0:NP];
  logic [VW-1:0]        sq_v    [0:NP];
  logic signed [XW-1:0] sq_lx   [0:NP];
  logic signed [XW-1:0] sq_ly   [0:NP];
  logic signed [ZW-1:0] sq_lz   [0:NP];

  assign sq_ctl[0]  = ctl2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_v[0]    = VW'({rr_r, {(2*FS){1'b0}}});
  assign sq_lx[0]   = lx2_r;
  assign sq_ly[0]   = ly2_r;
  assign sq_lz[0]   = lz2_r;

  for (genvar k = 0; k < NP; k++) begin : g_sqrt
    hrap_sqrt_cell #(.NP(NP), .XW(XW), .ZW(ZW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (sq_ctl[k]),
      .rem_i (sq_rem[k]),
      .root_i(sq_root[k]),
      .v_i   (sq_v[k]),
      .lx_i  (sq_lx[k]),
      .ly_i  (sq_ly[k]),
      .lz_i  (sq_lz[k]),
      .ctl_o (sq_ctl[k+1]),
      .rem_o (sq_rem[k+1]),
      .root_o(sq_root[k+1]),
      .v_o   (sq_v[k+1]),
      .lx_o  (sq_lx[k+1]),
      .ly_o  (sq_ly[k+1]),
      .lz_o  (sq_lz[k+1])
    );
  end

  // CORDIC chain: lane a = atan2(r, g), lane b = atan2(y, x) after pre-rotation
  hrap_pkg::ctl_t       cc_ctl [0:NS];
  logic signed [CW-1:0] ca_x [0:NS];
  logic signed [CW-1:0] ca_y [0:NS];
  logic signed [ZW-1:0] ca_z [0:NS];
  logic signed [CW-1:0] cb_x [0:NS];
  logic signed [CW-1:0] cb_y [0:NS];
  logic signed [ZW-1:0] cb_z [0:NS];

  assign cc_ctl[0] = sq_ctl[NP];
  assign ca_x[0]   = $signed({{(CW-27){1'b0}}, hrap_pkg::G_Q15});
  assign ca_y[0]   = $signed({{(CW-NP){1'b0}}, sq_root[NP]});
  assign ca_z[0]   = '0;
  assign cb_x[0]   = $signed({{(CW-XW-FS){sq_lx[NP][XW-1]}}, sq_lx[NP], {FS{1'b0}}});
  assign cb_y[0]   = $signed({{(CW-XW-FS){sq_ly[NP][XW-1]}}, sq_ly[NP], {FS{1'b0}}});
  assign cb_z[0]   = sq_lz[NP];

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    hrap_cordic_cell #(.CW(CW), .ZW(ZW), .IDX(i)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .ctl_i(cc_ctl[i]),
      .ax_i (ca_x[i]),
      .ay_i (ca_y[i]),
      .az_i (ca_z[i]),
      .bx_i (cb_x[i]),
      .by_i (cb_y[i]),
      .bz_i (cb_z[i]),
      .ctl_o(cc_ctl[i+1]),
      .ax_o (ca_x[i+1]),
      .ay_o (ca_y[i+1]),
      .az_o (ca_z[i+1]),
      .bx_o (cb_x[i+1]),
      .by_o (cb_y[i+1]),
      .bz_o (cb_z[i+1])
    );
  end

  // degree conversion, two stages; latitude angle is pi/2 - 2*phi
  logic signed [ZW-1:0] lat_rad;
  logic signed [DW-1:0] lat_deg, lon_deg;
  hrap_pkg::ctl_t       cv1_r, cv2_r;

  assign lat_rad = hrap_pkg::PI_HALF_Q32 - (ca_z[NS] <<< 1);

  hrap_deg_conv #(.ZW(ZW)) u_lat_conv (
    .clk  (clk),
    .en   (en),
    .rad_i(lat_rad),
    .deg_o(lat_deg)
  );

  hrap_deg_conv #(.ZW(ZW)) u_lon_conv (
    .clk  (clk),
    .en   (en),
    .rad_i(cb_z[NS]),
    .deg_o(lon_deg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv1_r <= '0;
      cv2_r <= '0;
    end else if (en) begin
      cv1_r <= cc_ctl[NS];
      cv2_r <= cv1_r;
    end
  end

  // final stage: saturate latitude, wrap longitude, pole override
  logic signed [DW-1:0] lat_s, ang, lon_a, lon_w;

  always_comb begin
    lat_s = lat_deg;
    if (lat_deg > hrap_pkg::DEG90) lat_s = hrap_pkg::DEG90;
    if (lat_deg < -hrap_pkg::DEG90) lat_s = -hrap_pkg::DEG90;
    ang = lon_deg[DW-1] ? lon_deg + hrap_pkg::DEG360 : lon_deg;
    lon_a = hrap_pkg::DEG375 - ang;
    if (lon_a[DW-1]) lon_w = lon_a + hrap_pkg::DEG360;
    else if (lon_a > hrap_pkg::DEG360) lon_w = lon_a - hrap_pkg::DEG360;
    else lon_w = lon_a;
    if (cv2_r.pole) begin
      olat_nxt = hrap_pkg::DEG90[23:0];
      olon_nxt = hrap_pkg::DEG15[24:0];
    end else begin
      olat_nxt = lat_s[23:0];
      olon_nxt = lon_w[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r         <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (en) ov_r <= cv2_r.valid;
      if (skid_valid_r) begin
        if (out_ch.ready) skid_valid_r <= 1'b0;
      end else if (ov_r && !out_ch.ready) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      olat_r     <= olat_nxt;
      olon_r     <= olon_nxt;
      skid_lat_r <= olat_r;
      skid_lon_r <= olon_r;
    end
  end

  assign out_ch.valid          = skid_valid_r || ov_r;
  assign out_ch.latitude       = skid_valid_r ? skid_lat_r : olat_r;
  assign out_ch.west_longitude = skid_valid_r ? skid_lon_r : olon_r;

endmodule
`default_nettype wire

[src/hrap_chk.sv]
// Port-level checks for hrap_grid_to_lat_lon_top, attached by bind.
// Uses hrap_grid_to_lat_lon_top_macros.svh.
`default_nettype none
`include "hrap_grid_to_lat_lon_top_macros.svh"
module hrap_chk (
  input wire              clk,
  input wire              rst_n,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire signed [23:0] latitude,
  input wire       [24:0] west_longitude
);

  `HRAP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `HRAP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(latitude))
  `HRAP_ASSERT(a_lat_range, out_valid |-> (latitude <= 24'sd5898240) && (latitude >= -24'sd5898240))
  `HRAP_ASSERT(a_lon_range, out_valid |-> west_longitude <= 25'd23592960)
  `HRAP_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid && in_ready)

endmodule

bind hrap_grid_to_lat_lon_top hrap_chk u_hrap_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .latitude      (out_ch.latitude),
  .west_longitude(out_ch.west_longitude)
);
`default_nettype wire

[sim/tb.sv]
// Testbench for hrap_grid_to_lat_lon_top: grid points in, latitude/longitude checked out.
// Depends on hrap_pkg, hrap_if and the converter RTL; self-contained stimulus and prediction.
`default_nettype none
module tb;

  localparam int CB         = 12;
  localparam int STEPS      = 24;
  localparam int POLE_C     = 401;
  localparam int POLE_R     = 1601;
  localparam int RAND_ITEMS = 1750;
  localparam int DRAIN_AT   = 900;     // sender waits for an empty pipe here
  localparam int HOLD_AT    = 300;     // receiver holds off after this many results
  localparam int HOLD_LEN   = 200;
  localparam int TAIL       = 120;     // wait after the last result before the verdict
  localparam int LIMIT      = 200000;

  localparam longint PI_HALF  = 64'sd6746518852;
  localparam longint PI_QUART = 64'sd3373259426;
  localparam longint G_SCALE  = 64'sd81800082;
  localparam longint DEG_RAD  = 64'd961263669;
  localparam longint DEGQ     = 64'sd65536;

  typedef struct {
    logic [CB-1:0] col;
    logic [CB-1:0] row;
  } grid_pt_t;

  typedef struct {
    logic signed [23:0] lat;
    logic        [24:0] lon;
  } geo_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hrap_in_if #(.COORD_BITS(CB)) in_ch ();
  hrap_out_if                   out_ch ();

  hrap_grid_to_lat_lon_top #(.COORD_BITS(CB), .CORDIC_STEPS(STEPS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: integer square root and CORDIC vectoring at the block's precision
  // ---------------------------------------------------------------------------
  longint atan_tbl [32];

  // atan(2^-i) in Q.32 from the arctangent series, kept in Q.62 then rounded
  function automatic void build_atan_tbl();
    longint acc, term;
    int e;
    atan_tbl[0] = PI_QUART;
    for (int i = 1; i < 32; i++) begin
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e < 0) break;
        term = (64'sd1 <<< e) / (2 * k + 1);
        acc = (k & 1) ? acc - term : acc + term;
      end
      atan_tbl[i] = (acc + (64'sd1 <<< 29)) >>> 30;
    end
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // returns z + atan2(y, x) for x >= 0; shifts floor
  function automatic longint cordic_vec(longint x, longint y, longint z);
    longint dx, dy;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_tbl[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_tbl[i];
      end
    end
    return z;
  endfunction

  // radians Q.32 to degrees Q.16, rounding half away from zero
  function automatic longint to_degrees(longint rad);
    longint unsigned m, a, b, t;
    longint d;
    m = (rad < 0) ? longint'(-rad) : longint'(rad);
    a = m >> 16;
    b = m & 64'hFFFF;
    t = a * DEG_RAD + ((b * DEG_RAD) >> 16);
    d = longint'((t + (64'd1 << 23)) >> 24);
    return (rad < 0) ? -d : d;
  endfunction

  function automatic geo_pt_t project_point(grid_pt_t p);
    geo_pt_t res;
    longint x, y, r, phi, lat, lon, ang, px, py, pz;
    x = longint'(p.col) - POLE_C;
    y = longint'(p.row) - POLE_R;
    if (x == 0 && y == 0) begin
      lat = 90 * DEGQ;
      lon = 15 * DEGQ;
    end else begin
      r = int_sqrt(longint'(x * x + y * y) << 30);
      phi = cordic_vec(G_SCALE, r, 0);
      lat = to_degrees(PI_HALF - 2 * phi);
      if (lat > 90 * DEGQ) lat = 90 * DEGQ;
      if (lat < -90 * DEGQ) lat = -90 * DEGQ;
      // left half-plane: rotate by a quarter turn into x >= 0 first
      px = x <<< 15;
      py = y <<< 15;
      pz = 0;
      if (px < 0) begin
        if (py >= 0) begin
          pz = PI_HALF; px = py; py = -(x <<< 15);
        end else begin
          pz = -PI_HALF; px = -py; py = x <<< 15;
        end
      end
      ang = to_degrees(cordic_vec(px, py, pz));
      if (ang < 0) ang = ang + 360 * DEGQ;
      lon = 375 * DEGQ - ang;
      if (lon < 0) lon = lon + 360 * DEGQ;
      else if (lon > 360 * DEGQ) lon = lon - 360 * DEGQ;
    end
    res.lat = lat[23:0];
    res.lon = lon[24:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  grid_pt_t pending_pts [$];
  geo_pt_t  expected_geo [$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_recv = 0;
  int       cycle_cnt = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_recv, what, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transaction from the pending queue, random gap between items
  // ---------------------------------------------------------------------------
  int gap_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.grid_col <= '0;
      in_ch.grid_row <= '0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      // accepted this edge: predict now, from the values on the bus
      if (in_ch.valid) begin
        grid_pt_t acc_pt;
        acc_pt.col = in_ch.grid_col;
        acc_pt.row = in_ch.grid_row;
        expected_geo.push_back(project_point(acc_pt));
        n_sent++;
      end
      if (gap_cnt > 0) begin
        gap_cnt--;
        in_ch.valid <= 1'b0;
      end else if (pending_pts.size() > 0 &&
                   !(n_sent == DRAIN_AT && expected_geo.size() != 0)) begin
        grid_pt_t nxt;
        nxt = pending_pts.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.grid_col <= nxt.col;
        in_ch.grid_row <= nxt.row;
        // every other block of 256 items runs back to back
        gap_cnt = (n_sent[8]) ? 0 : $urandom_range(0, 8);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, one long hold-off, field-by-field compare
  // ---------------------------------------------------------------------------
  int stall_cnt = 0;
  int hold_cnt = 0;
  bit held_once = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_geo.size() == 0) begin
          $display("unexpected result transaction %0d", n_recv);
          n_errors++;
        end else begin
          geo_pt_t want;
          want = expected_geo.pop_front();
          if (out_ch.latitude !== want.lat)
            report_mismatch("latitude", out_ch.latitude, want.lat);
          if (out_ch.west_longitude !== want.lon)
            report_mismatch("west_longitude", out_ch.west_longitude, want.lon);
        end
        n_recv++;
        stall_cnt = (n_recv[7]) ? 0 : $urandom_range(0, 8);
        if (n_recv == HOLD_AT && !held_once) begin
          hold_cnt = HOLD_LEN;
          held_once = 1'b1;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  task automatic add_pt(int c, int r);
    grid_pt_t p;
    p.col = c[CB-1:0];
    p.row = r[CB-1:0];
    pending_pts.push_back(p);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.grid_col = '0;
    in_ch.grid_row = '0;
    out_ch.ready = 1'b0;
    build_atan_tbl();

    // directed: pole, axes, corners, neighbours of the pole
    add_pt(POLE_C, POLE_R);
    add_pt(0, POLE_R);              // negative x axis
    add_pt(4095, POLE_R);           // positive x axis, wraps above 360
    add_pt(POLE_C, 0);
    add_pt(POLE_C, 4095);
    add_pt(0, 0);
    add_pt(0, 4095);
    add_pt(4095, 0);
    add_pt(4095, 4095);
    add_pt(POLE_C + 1, POLE_R);
    add_pt(POLE_C - 1, POLE_R);
    add_pt(POLE_C, POLE_R + 1);
    add_pt(POLE_C, POLE_R - 1);
    add_pt(POLE_C - 1, POLE_R - 1);
    add_pt(POLE_C + 1, POLE_R + 1);
    add_pt(POLE_C, POLE_R);
    add_pt(12'hAAA, 12'h555);
    add_pt(12'h555, 12'hAAA);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      case ($urandom_range(0, 3))
        0: add_pt($urandom_range(POLE_C - 20, POLE_C + 20),
                  $urandom_range(POLE_R - 20, POLE_R + 20));
        1: add_pt($urandom_range(0, 4095), POLE_R);
        default: add_pt($urandom_range(0, 4095), $urandom_range(0, 4095));
      endcase
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_pts.size() == 0 && !in_ch.valid);
    wait (expected_geo.size() == 0);
    repeat (TAIL) @(posedge clk);

    if (n_errors == 0 && expected_geo.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
+incdir+src
src/hrap_pkg.sv
src/hrap_if.sv
src/hrap_sqrt_cell.sv
src/hrap_cordic_cell.sv
src/hrap_deg_conv.sv
src/hrap_grid_to_lat_lon_top.sv
src/hrap_chk.sv
sim/tb.sv
